[rtl/core/set_assoc_transposition_table_defines.svh]
// assertion macros for the transposition table checker
`ifndef SET_ASSOC_TRANSPOSITION_TABLE_DEFINES_SVH
`define SET_ASSOC_TRANSPOSITION_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SATTT_ASSERT_NOW(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("sattt check failed");

// next-cycle implication, disabled during reset
`define SATTT_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("sattt check failed");

`endif

[rtl/core/sattt_pkg.sv]
// shared types and constants of the transposition table
package sattt_pkg;

  localparam int unsigned TAG_W     = 16;
  localparam int unsigned HASH_HI_W = 48;
  localparam int unsigned AGE_BIAS  = 32;

  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] BOUND_EMPTY = 2'd0;
  localparam logic [1:0] BOUND_EXACT = 2'd1;

  localparam logic CFG_GEN = 1'b0;
  localparam logic CFG_THR = 1'b1;

  localparam logic [14:0] THR_RESET = 15'd30000;

  typedef struct packed {
    logic [15:0]        tag;
    logic               pv;
    logic [7:0]         move;
    logic signed [15:0] value;
    logic [7:0]         depth;
    logic [1:0]         bound;
    logic [7:0]         gen;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WIPE,
    ST_INDEX,
    ST_READ,
    ST_LOOK,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic idx_step;
    logic mem_read;
    logic look;
    logic mem_write;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic req_clear;
    logic req_work;
    logic idx_ready;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/sattt_ctrl.sv]
// sequencing state machine of the transposition table
module sattt_ctrl
  import sattt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.req_clear) begin
            state_d = ST_WIPE;
          end else if (sts_i.req_work) begin
            state_d = ST_INDEX;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WIPE: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = ST_DONE;
      end
      ST_INDEX: begin
        cmd_o.idx_step = 1'b1;
        if (sts_i.idx_ready) state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = ST_LOOK;
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.mem_write = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

[rtl/core/sattt_dp.sv]
// datapath: cluster memory, index reduction, way selection and result register
module sattt_dp
  import sattt_pkg::*;
#(
  parameter int unsigned NUM_CLUSTERS = 4096,
  parameter int unsigned CLUSTER_WAYS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [1:0]         operation_i,
  input  logic [63:0]        hash_key_i,
  input  logic [1:0]         way_sel_i,
  input  logic               pv_flag_i,
  input  logic [7:0]         best_move_i,
  input  logic signed [15:0] score_i,
  input  logic [7:0]         search_depth_i,
  input  logic [7:0]         ply_step_i,
  input  logic [1:0]         bound_kind_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [1:0]         way_out_o,
  output logic               entry_pv_o,
  output logic [7:0]         entry_move_o,
  output logic signed [15:0] entry_value_o,
  output logic [7:0]         entry_depth_o,
  output logic [1:0]         entry_bound_o,
  output logic               written_o
);

  localparam int unsigned CIW = (NUM_CLUSTERS > 1) ? $clog2(NUM_CLUSTERS) : 1;
  localparam int unsigned WIW = (CLUSTER_WAYS > 1) ? $clog2(CLUSTER_WAYS) : 1;
  localparam bit IS_POW2 = ((NUM_CLUSTERS & (NUM_CLUSTERS - 1)) == 0);

  typedef entry_t [CLUSTER_WAYS-1:0] row_t;

  // request registers
  logic [1:0]         op_q;
  logic [15:0]        tag_q;
  logic [1:0]         sel_q;
  logic               pv_q;
  logic [7:0]         move_q;
  logic signed [15:0] score_q;
  logic [7:0]         depth_q;
  logic [7:0]         ply_q;
  logic [1:0]         bound_q;

  // configuration
  logic [7:0]  gen_q;
  logic [14:0] thr_q;

  // memory
  row_t           mem_q [NUM_CLUSTERS];
  row_t           row_q;
  row_t           wr_row_q;
  logic           wr_en_q;
  logic [CIW-1:0] cluster;
  logic [CIW-1:0] sweep_cnt_q;
  logic           mem_we;
  logic [CIW-1:0] mem_wa;
  row_t           mem_wd;

  // result registers
  logic               r_hit_q;
  logic [1:0]         r_way_q;
  entry_t             r_ent_q;
  logic               r_written_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= operation_i;
      tag_q   <= hash_key_i[TAG_W-1:0];
      sel_q   <= way_sel_i;
      pv_q    <= pv_flag_i;
      move_q  <= best_move_i;
      score_q <= score_i;
      depth_q <= search_depth_i;
      ply_q   <= ply_step_i;
      bound_q <= bound_kind_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= '0;
      thr_q <= THR_RESET;
    end else if (cmd_i.accept && operation_i == OP_CLEAR) begin
      gen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GEN: gen_q <= cfg_data_i[7:0];
        CFG_THR: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // cluster index from hash bits above the tag
  if (IS_POW2) begin : g_idx_mask
    logic [CIW-1:0] cl_q;
    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        cl_q <= (NUM_CLUSTERS > 1) ? hash_key_i[TAG_W +: CIW] : '0;
      end
    end
    assign cluster         = cl_q;
    assign sts_o.idx_ready = 1'b1;
  end else begin : g_idx_serial
    // one hash byte at a time in two phases: quotient estimate, then remainder with one correction
    localparam int unsigned      RED_W = CIW + 8;
    localparam logic [RED_W-1:0] N_RED = RED_W'(NUM_CLUSTERS);
    localparam logic [8:0]       RECIP = 9'((64'd1 << RED_W) / 64'(NUM_CLUSTERS));
    logic [CIW-1:0]       rem_q;
    logic [HASH_HI_W-1:0] sh_q;
    logic [2:0]           bcnt_q;
    logic                 ph_q;
    logic [8:0]           quo_q;
    logic [RED_W-1:0]     s_red;
    logic [RED_W+8:0]     prod;
    logic [RED_W-1:0]     r_red;
    always_comb begin
      s_red = {rem_q, sh_q[HASH_HI_W-1 -: 8]};
      prod  = (RED_W+9)'(s_red) * (RED_W+9)'(RECIP);
      r_red = s_red - RED_W'(quo_q) * N_RED;
      if (r_red >= N_RED) r_red = r_red - N_RED;
    end
    always_ff @(posedge clk_i) begin
      if (cmd_i.accept) begin
        rem_q <= '0;
        sh_q  <= hash_key_i[63:TAG_W];
      end else if (cmd_i.idx_step && bcnt_q != '0) begin
        if (!ph_q) begin
          quo_q <= prod[RED_W +: 9];
        end else begin
          rem_q <= r_red[CIW-1:0];
          sh_q  <= {sh_q[HASH_HI_W-9:0], 8'd0};
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bcnt_q <= '0;
        ph_q   <= 1'b0;
      end else if (cmd_i.accept) begin
        bcnt_q <= 3'(HASH_HI_W / 8);
        ph_q   <= 1'b0;
      end else if (cmd_i.idx_step && bcnt_q != '0) begin
        ph_q <= !ph_q;
        if (ph_q) bcnt_q <= bcnt_q - 3'd1;
      end
    end
    assign cluster         = rem_q;
    assign sts_o.idx_ready = (bcnt_q == '0);
  end

  // clearing sweep, one row a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_cnt_q <= sts_o.sweep_last ? '0 : sweep_cnt_q + CIW'(1);
    end
  end

  assign sts_o.sweep_last = (sweep_cnt_q == CIW'(NUM_CLUSTERS - 1));
  assign sts_o.req_clear  = (operation_i == OP_CLEAR);
  assign sts_o.req_work   = (operation_i == OP_PROBE) || (operation_i == OP_STORE);

  assign mem_we = cmd_i.sweep || (cmd_i.mem_write && wr_en_q);
  assign mem_wa = cmd_i.sweep ? sweep_cnt_q : cluster;
  assign mem_wd = cmd_i.sweep ? row_t'('0) : wr_row_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (cmd_i.mem_read) row_q <= mem_q[cluster];
  end

  // way selection and store decision
  function automatic logic signed [10:0] repl_score(input entry_t e, input logic [7:0] g);
    logic [7:0] age;
    age = g - e.gen;
    return $signed({3'b000, e.depth}) - $signed(11'(AGE_BIAS)) - $signed({3'b000, age});
  endfunction

  logic                found;
  logic [WIW-1:0]      fidx;
  logic [WIW-1:0]      vidx;
  logic signed [10:0]  best_s;
  logic signed [10:0]  cur_s;
  logic [WIW-1:0]      chosen;
  entry_t              ch_e;
  logic                sel_ok;
  logic [WIW-1:0]      sel_idx;
  entry_t              st_old;
  entry_t              st_new;
  logic signed [17:0]  v18;
  logic signed [17:0]  thr18;
  logic signed [17:0]  step18;
  logic                lk_hit;
  logic [1:0]          lk_way;
  entry_t              lk_ent;
  logic                lk_wr;
  logic                lk_written;
  row_t                lk_row;

  always_comb begin
    found  = 1'b0;
    fidx   = '0;
    for (int i = 0; i < CLUSTER_WAYS; i++) begin
      if (!found && (row_q[i].tag == tag_q || row_q[i].bound == BOUND_EMPTY)) begin
        found = 1'b1;
        fidx  = WIW'(i);
      end
    end
    vidx   = '0;
    best_s = repl_score(row_q[0], gen_q);
    for (int i = 1; i < CLUSTER_WAYS; i++) begin
      cur_s = repl_score(row_q[i], gen_q);
      if (cur_s < best_s) begin
        best_s = cur_s;
        vidx   = WIW'(i);
      end
    end
    cur_s  = best_s;
    chosen = found ? fidx : vidx;
    ch_e   = row_q[chosen];

    sel_ok  = (int'(sel_q) < CLUSTER_WAYS);
    sel_idx = WIW'(sel_q);
    st_old  = row_q[sel_idx];

    v18    = $signed({{2{score_q[15]}}, score_q});
    thr18  = $signed({3'b000, thr_q});
    step18 = $signed({10'b0, ply_q});
    if (v18 >= thr18) begin
      v18 = v18 + step18;
    end else if (v18 <= -thr18) begin
      v18 = v18 - step18;
    end
    if (v18 > 18'sd32767) v18 = 18'sd32767;
    if (v18 < -18'sd32768) v18 = -18'sd32768;

    st_new.tag   = tag_q;
    st_new.pv    = pv_q;
    st_new.move  = move_q;
    st_new.value = v18[15:0];
    st_new.depth = depth_q;
    st_new.bound = bound_q;
    st_new.gen   = gen_q;

    lk_row     = row_q;
    lk_hit     = 1'b0;
    lk_way     = '0;
    lk_ent     = '0;
    lk_wr      = 1'b0;
    lk_written = 1'b0;
    if (op_q == OP_PROBE) begin
      lk_hit = found && (ch_e.tag == tag_q);
      lk_way = 2'(chosen);
      lk_ent = ch_e;
      lk_wr  = found;
      lk_row[fidx].gen = gen_q;
    end else begin
      lk_wr      = sel_ok && ((st_old.tag != tag_q) || (depth_q >= st_old.depth) ||
                              (bound_q == BOUND_EXACT));
      lk_written = lk_wr;
      lk_row[sel_idx] = st_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      r_hit_q     <= 1'b0;
      r_way_q     <= '0;
      r_ent_q     <= '0;
      r_written_q <= (operation_i == OP_CLEAR);
    end else if (cmd_i.look) begin
      r_hit_q     <= lk_hit;
      r_way_q     <= lk_way;
      r_ent_q     <= lk_ent;
      r_written_q <= lk_written;
      wr_row_q    <= lk_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
    end else if (cmd_i.accept) begin
      wr_en_q <= 1'b0;
    end else if (cmd_i.look) begin
      wr_en_q <= lk_wr;
    end
  end

  // output register
  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hit_o         <= r_hit_q;
      way_out_o     <= r_way_q;
      entry_pv_o    <= r_ent_q.pv;
      entry_move_o  <= r_ent_q.move;
      entry_value_o <= r_ent_q.value;
      entry_depth_o <= r_ent_q.depth;
      entry_bound_o <= r_ent_q.bound;
      written_o     <= r_written_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/set_assoc_transposition_table.sv]
// top level of the set-associative transposition table
// One request at a time. A probe or store passes through index, memory read, way
// compare and write-back after acceptance; when NUM_CLUSTERS is not a power of
// two, the index step reduces the cluster index one hash byte at a time. Each
// cluster is one memory row holding all its ways, read once and written at most
// once per probe or store. A clear request, and the start-up after reset, sweep
// the memory one row a cycle, during which in_stall_o is high.
// The result sits in an output register, so the next request is taken while a
// result waits.
module set_assoc_transposition_table
  import sattt_pkg::*;
#(
  parameter int unsigned NUM_CLUSTERS = 4096,
  parameter int unsigned CLUSTER_WAYS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [63:0]        hash_key_i,
  input  logic [1:0]         way_sel_i,
  input  logic               pv_flag_i,
  input  logic [7:0]         best_move_i,
  input  logic signed [15:0] score_i,
  input  logic [7:0]         search_depth_i,
  input  logic [7:0]         ply_step_i,
  input  logic [1:0]         bound_kind_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               hit_o,
  output logic [1:0]         way_out_o,
  output logic               entry_pv_o,
  output logic [7:0]         entry_move_o,
  output logic signed [15:0] entry_value_o,
  output logic [7:0]         entry_depth_o,
  output logic [1:0]         entry_bound_o,
  output logic               written_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [14:0]        cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  sattt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sattt_dp #(
    .NUM_CLUSTERS (NUM_CLUSTERS),
    .CLUSTER_WAYS (CLUSTER_WAYS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .operation_i    (operation_i),
    .hash_key_i     (hash_key_i),
    .way_sel_i      (way_sel_i),
    .pv_flag_i      (pv_flag_i),
    .best_move_i    (best_move_i),
    .score_i        (score_i),
    .search_depth_i (search_depth_i),
    .ply_step_i     (ply_step_i),
    .bound_kind_i   (bound_kind_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .way_out_o      (way_out_o),
    .entry_pv_o     (entry_pv_o),
    .entry_move_o   (entry_move_o),
    .entry_value_o  (entry_value_o),
    .entry_depth_o  (entry_depth_o),
    .entry_bound_o  (entry_bound_o),
    .written_o      (written_o)
  );

endmodule

[rtl/core/sattt_checker.sv]
// port-level checks of the transposition table and their binding
`include "set_assoc_transposition_table_defines.svh"

module sattt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         operation_i,
  input logic [63:0]        hash_key_i,
  input logic [1:0]         way_sel_i,
  input logic               pv_flag_i,
  input logic [7:0]         best_move_i,
  input logic signed [15:0] score_i,
  input logic [7:0]         search_depth_i,
  input logic [7:0]         ply_step_i,
  input logic [1:0]         bound_kind_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               hit_o,
  input logic [1:0]         way_out_o,
  input logic               entry_pv_o,
  input logic [7:0]         entry_move_o,
  input logic signed [15:0] entry_value_o,
  input logic [7:0]         entry_depth_o,
  input logic [1:0]         entry_bound_o,
  input logic               written_o,
  input logic               cfg_we_i,
  input logic               cfg_index_i,
  input logic [14:0]        cfg_data_i
);

  // one request in flight: a taken request closes the input
  `SATTT_ASSERT_NEXT(a_one_in_flight, in_valid_i && !in_stall_o, in_stall_o)
  // a stalled result stays offered
  `SATTT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  // a write report never comes with a hit
  `SATTT_ASSERT_NOW(a_written_no_hit, out_valid_o && written_o, !hit_o)

endmodule

bind set_assoc_transposition_table sattt_checker u_sattt_checker (.*);

[test/set_assoc_transposition_table_tb.sv]
// testbench for the set-associative transposition table, self-checking with a table model
module set_assoc_transposition_table_tb;
  import sattt_pkg::*;

  localparam int NCLUS = 4096;
  localparam int NWAYS = 4;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [1:0]         op;
    logic [63:0]        hash;
    logic [1:0]         way;
    logic               pv;
    logic [7:0]         move;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [7:0]         ply;
    logic [1:0]         bound;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         way;
    logic               pv;
    logic [7:0]         move;
    logic signed [15:0] value;
    logic [7:0]         depth;
    logic [1:0]         bound;
    logic               written;
  } answer_t;

  class tt_scoreboard;
    entry_t    slots[NCLUS*NWAYS];
    logic [7:0]  cur_gen;
    logic [14:0] win_thr;
    answer_t   pending[$];
    int        mismatches, checked, hits, victims, stores_written, clears;

    function new();
      foreach (slots[i]) slots[i] = '0;
      cur_gen = 8'd0;
      win_thr = THR_RESET;
    endfunction

    function void set_reg(logic idx, logic [14:0] data);
      if (idx == CFG_GEN) cur_gen = data[7:0];
      else win_thr = data;
    endfunction

    function answer_t from_slot(entry_t e, logic h, int w);
      answer_t a;
      a = '{default: '0};
      a.hit = h;
      a.way = w[1:0];
      a.pv = e.pv;
      a.move = e.move;
      a.value = e.value;
      a.depth = e.depth;
      a.bound = e.bound;
      return a;
    endfunction

    function void note_request(req_t r);
      answer_t a;
      int base, best, age, s, best_s, val;
      logic found;
      a = '{default: '0};
      base = int'(r.hash[27:16]) * NWAYS;
      found = 1'b0;
      if (r.op == OP_PROBE) begin
        for (int i = 0; i < NWAYS; i++) begin
          if (!found && (slots[base+i].tag == r.hash[15:0] ||
                         slots[base+i].bound == BOUND_EMPTY)) begin
            found = 1'b1;
            slots[base+i].gen = cur_gen;
            a = from_slot(slots[base+i], slots[base+i].tag == r.hash[15:0], i);
            if (a.hit) hits++;
          end
        end
        if (!found) begin
          best = 0;
          best_s = 0;
          for (int i = 0; i < NWAYS; i++) begin
            age = int'(8'(cur_gen - slots[base+i].gen));
            s = int'(slots[base+i].depth) - (AGE_BIAS + age);
            if (i == 0 || s < best_s) begin
              best_s = s;
              best = i;
            end
          end
          victims++;
          a = from_slot(slots[base+best], 1'b0, best);
        end
      end else if (r.op == OP_STORE) begin
        if (slots[base+r.way].tag != r.hash[15:0] || r.depth >= slots[base+r.way].depth ||
            r.bound == BOUND_EXACT) begin
          val = int'(r.score);
          if (val >= int'(win_thr)) val += int'(r.ply);
          else if (val <= -int'(win_thr)) val -= int'(r.ply);
          if (val > 32767) val = 32767;
          if (val < -32768) val = -32768;
          slots[base+r.way].tag = r.hash[15:0];
          slots[base+r.way].pv = r.pv;
          slots[base+r.way].move = r.move;
          slots[base+r.way].value = 16'(val);
          slots[base+r.way].depth = r.depth;
          slots[base+r.way].bound = r.bound;
          slots[base+r.way].gen = cur_gen;
          a.written = 1'b1;
          stores_written++;
        end
      end else if (r.op == OP_CLEAR) begin
        foreach (slots[i]) slots[i] = '0;
        cur_gen = 8'd0;
        a.written = 1'b1;
        clears++;
      end
      pending.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 1'b0, rst_ni = 1'b0;
  logic in_valid = 1'b0, out_stall = 1'b0, in_stall, out_valid;
  req_t cur = '{default: '0};
  answer_t got;
  logic cfg_we = 1'b0, cfg_idx = CFG_GEN;
  logic [14:0] cfg_data = '0;
  tt_scoreboard sb;
  int cycles = 0;
  int idle_pct = 36;
  int hold_cycles = 0;
  logic sender_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_assoc_transposition_table dut (
    .clk_i(clk), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .operation_i(cur.op), .hash_key_i(cur.hash), .way_sel_i(cur.way),
    .pv_flag_i(cur.pv), .best_move_i(cur.move), .score_i(cur.score),
    .search_depth_i(cur.depth), .ply_step_i(cur.ply), .bound_kind_i(cur.bound),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .hit_o(got.hit), .way_out_o(got.way), .entry_pv_o(got.pv),
    .entry_move_o(got.move), .entry_value_o(got.value), .entry_depth_o(got.depth),
    .entry_bound_o(got.bound), .written_o(got.written),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[set_assoc_transposition_table] ERROR");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (rst_ni && out_valid && !out_stall) sb.check_answer(got);
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  task automatic send(req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cur = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic idx, logic [14:0] data);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic req_t mk(logic [1:0] op, logic [63:0] hash, logic [1:0] way,
                              logic signed [15:0] score, logic [7:0] depth,
                              logic [7:0] ply, logic [1:0] bound);
    req_t r;
    r.op = op; r.hash = hash; r.way = way; r.pv = $urandom_range(1);
    r.move = $urandom_range(255); r.score = score; r.depth = depth;
    r.ply = ply; r.bound = bound;
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int pick;
    r.hash = {$urandom, $urandom};
    if ($urandom_range(9) != 0) begin
      r.hash[27:16] = 12'($urandom_range(7));
      r.hash[15:0] = 16'($urandom_range(6));
    end
    pick = $urandom_range(999);
    if (pick < 470) r.op = OP_PROBE;
    else if (pick < 990) r.op = OP_STORE;
    else if (pick < 997) r.op = 2'd3;
    else r.op = OP_CLEAR;
    r.way = $urandom_range(3);
    r.pv = $urandom_range(1);
    r.move = $urandom_range(255);
    case ($urandom_range(3))
      0: r.score = 16'($urandom);
      1: r.score = 16'(int'(sb.win_thr) + $urandom_range(4) - 2);
      2: r.score = 16'(-int'(sb.win_thr) + $urandom_range(4) - 2);
      default: r.score = $urandom_range(1) ? 16'sh7fff - 16'($urandom_range(3))
                                           : 16'sh8000 + 16'($urandom_range(3));
    endcase
    r.depth = $urandom_range(255);
    r.ply = $urandom_range(255);
    r.bound = $urandom_range(3);
    return r;
  endfunction

  initial begin
    logic [7:0]  gens[5];
    logic [14:0] thrs[5];
    gens = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd3};
    thrs = '{15'd30000, 15'd32767, 15'd0, 15'd100, 15'd1};
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);

    // directed
    send(mk(OP_PROBE, 64'h0, 0, 0, 0, 0, 0));
    send(mk(OP_STORE, 64'h1_0005, 0, 16'sh7fff, 8'd10, 8'd255, BOUND_EXACT));
    send(mk(OP_STORE, 64'h1_0006, 1, 16'sh8000, 8'd0, 8'd255, 2'd2));
    send(mk(OP_STORE, 64'h1_0007, 2, 16'sd29999, 8'd255, 8'd9, 2'd3));
    send(mk(OP_STORE, 64'h1_0008, 3, -16'sd30000, 8'd1, 8'd1, 2'd2));
    send(mk(OP_PROBE, 64'h1_0005, 0, 0, 0, 0, 0));
    send(mk(OP_PROBE, 64'h1_0009, 0, 0, 0, 0, 0));
    send(mk(OP_STORE, 64'h1_0008, 3, 16'sd5, 8'd0, 8'd3, 2'd2));
    send(mk(OP_STORE, 64'h1_0008, 3, 16'sd5, 8'd0, 8'd3, BOUND_EXACT));
    send(mk(OP_STORE, 64'hffff_ffff_ffff_ffff, 3, 16'sd30000, 8'd255, 8'd7, 2'd2));
    send(mk(OP_PROBE, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0, 0));
    send(mk(2'd3, 64'hffff_ffff_ffff_ffff, 3, 16'shffff, 8'd255, 8'd255, 2'd3));
    send(mk(OP_CLEAR, 64'h0, 0, 0, 0, 0, 0));
    send(mk(OP_PROBE, 64'h1_0005, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_GEN, {7'd0, gens[ph]});
      write_reg(CFG_THR, thrs[ph]);
      idle_pct = (ph == 1) ? 0 : 36;
      if (ph == 2) hold_cycles = 300;
      for (int n = 0; n < 200; n++) begin
        if (ph == 3 && n == 100 && sb.pending.size() == 0)
          write_reg(CFG_GEN, 15'd200);
        send(rand_req());
      end
      drain();
    end
    sender_done = 1'b1;
    idle_pct = 20;
    drain();

    $display("checked %0d results: %0d hits, %0d victim picks, %0d writes, %0d clears",
             sb.checked, sb.hits, sb.victims, sb.stores_written, sb.clears);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[set_assoc_transposition_table] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("[set_assoc_transposition_table] ERROR");
    end
    $finish;
  end

endmodule
